@@ hw/rtl/pag_pkg.sv @@
// ----------------------------------------------------------------------------
// pag_pkg: shared types and constants of the patchify address generator
// Field widths, range limits, microcode opcodes and the structs that run
// between the sequencer, the datapath and the divider.
// ----------------------------------------------------------------------------
package pag_pkg;

    localparam int MAX_SIDE       = 2048;
    localparam int MAX_CHANNELS   = 4;
    localparam int MAX_BATCH      = 16;
    localparam int MAX_PATCH_SIDE = 64;
    localparam int MAX_KERNEL     = 8;

    localparam int SIDE_W      = 12;
    localparam int BATCH_CFG_W = 5;
    localparam int CHAN_CFG_W  = 3;
    localparam int PSIDE_CFG_W = 7;
    localparam int KERN_CFG_W  = 4;
    localparam int LIMIT_W     = 23;
    localparam int CFG_DATA_W  = 23;
    localparam int CFG_IDX_W   = 3;
    localparam int IDX_W       = 28;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 80;

    localparam int POS_W   = $clog2(MAX_SIDE);
    localparam int BPOS_W  = $clog2(MAX_BATCH);
    localparam int CPOS_W  = $clog2(MAX_CHANNELS);
    localparam int INNER_W = $clog2(MAX_PATCH_SIDE * MAX_KERNEL);
    localparam int MP_W    = INNER_W + 1;
    localparam int MPP_W   = PSIDE_CFG_W + KERN_CFG_W;
    localparam int ROWG_W  = $clog2(MAX_BATCH * MAX_SIDE);
    localparam int P_W     = ROWG_W + SIDE_W;
    localparam int PROD_W  = 2 * SIDE_W;
    localparam int KK_W    = 2 * KERN_CFG_W;
    localparam int PK_W    = PROD_W + KK_W;
    localparam int PC_W    = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_NOT_DIVISIBLE = 2'd1,
        ST_TOO_MANY      = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BATCH_COUNT      = 3'd0,
        REG_IMAGE_HEIGHT     = 3'd1,
        REG_IMAGE_WIDTH      = 3'd2,
        REG_CHANNEL_COUNT    = 3'd3,
        REG_SUB_PATCH_HEIGHT = 3'd4,
        REG_SUB_PATCH_WIDTH  = 3'd5,
        REG_MERGE_KERNEL     = 3'd6,
        REG_PATCH_LIMIT      = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MP,
        OP_DIVH_GO,
        OP_DIVH_END,
        OP_DIVW_GO,
        OP_DIVW_END,
        OP_CNT,
        OP_LIM,
        OP_CHECK,
        OP_WAIT,
        OP_MUL1,
        OP_MUL2,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        C_NONE,
        C_DIV_BUSY,
        C_NO_INPUT,
        C_OUT_FULL
    } t_cond;

    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond hold;
        t_pc   next;
    } t_ctrl;

    typedef struct packed {
        logic div_busy;
        logic in_valid;
        logic out_full;
    } t_flags;

    typedef struct packed {
        logic [SIDE_W-1:0]      h;
        logic [SIDE_W-1:0]      w;
        logic [PSIDE_CFG_W-1:0] sph;
        logic [PSIDE_CFG_W-1:0] spw;
        logic [KERN_CFG_W-1:0]  k;
        logic [CHAN_CFG_W-1:0]  c;
        logic [CPOS_W-1:0]      c_m1;
        logic [BPOS_W-1:0]      nb_m1;
        logic [LIMIT_W-1:0]     limit;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [SIDE_W-1:0] dividend;
        logic [MP_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [SIDE_W-1:0] quot;
        logic [MP_W-1:0]   rem;
    } t_div_rsp;

    typedef struct packed {
        logic [IDX_W-1:0] source_index;
        logic [IDX_W-1:0] dest_index;
        logic [POS_W-1:0] patch_col;
        logic [POS_W-1:0] patch_row;
        logic             patch_start;
        logic             last;
        t_status          status;
    } t_result;

endpackage

@@ hw/rtl/patchify_address_generator.sv @@
// ----------------------------------------------------------------------------
// patchify_address_generator: patch-major gather address generator
// Usage:
//   Write the eight geometry registers through i_cfg_we/i_cfg_index/i_cfg_data
//   while the block is idle. Every write returns the walk to the first element
//   and reruns the setup program (the patch multiply, two divisions, and the
//   count, limit and check steps) during which s_axis_tready stays low.
//   Each word on the slave stream (s_axis_tdata[0] = restart) yields one word
//   on the master stream: source and destination element index, model patch
//   column/row and patch-start flag in tdata, status in tuser, end of pass
//   (or error) in tlast.
//   After the input word is taken, the row multiply, column/channel multiply
//   and emit steps follow; emit registers the word and raises m_axis_tvalid.
//   The next input word is taken only when this loop returns to wait.
//   A stalled receiver holds the output register; the next input word is
//   taken while it waits, and its emit step holds until the register frees.
//   Reset restores the register defaults, clears the walk and runs setup.
// ----------------------------------------------------------------------------
module patchify_address_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pag_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pag_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] restart
    input  logic [pag_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [27:0] source_index, [55:28] dest_index, [66:56] patch_col,
    // [77:67] patch_row, [78] patch_start
    output logic [pag_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [1:0] status
    output logic [pag_pkg::STATUS_W-1:0]       m_axis_tuser,
    output logic                               m_axis_tlast
);

    logic [pag_pkg::BATCH_CFG_W-1:0] r_batch_count;
    logic [pag_pkg::SIDE_W-1:0]      r_image_height;
    logic [pag_pkg::SIDE_W-1:0]      r_image_width;
    logic [pag_pkg::CHAN_CFG_W-1:0]  r_channel_count;
    logic [pag_pkg::PSIDE_CFG_W-1:0] r_sub_patch_height;
    logic [pag_pkg::PSIDE_CFG_W-1:0] r_sub_patch_width;
    logic [pag_pkg::KERN_CFG_W-1:0]  r_merge_kernel;
    logic [pag_pkg::LIMIT_W-1:0]     r_patch_limit;

    logic                    r_out_valid;
    pag_pkg::t_result        r_out;

    pag_pkg::t_cfg           cfg;
    logic [pag_pkg::BATCH_CFG_W-1:0] nb;
    pag_pkg::t_flags         flags;
    pag_pkg::t_ctrl          ctrl;
    logic                    fire;
    pag_pkg::t_div_req       div_req;
    pag_pkg::t_div_rsp       div_rsp;
    pag_pkg::t_result        dp_result;
    logic                    emit_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_count      <= pag_pkg::BATCH_CFG_W'(1);
            r_image_height     <= pag_pkg::SIDE_W'(224);
            r_image_width      <= pag_pkg::SIDE_W'(224);
            r_channel_count    <= pag_pkg::CHAN_CFG_W'(3);
            r_sub_patch_height <= pag_pkg::PSIDE_CFG_W'(14);
            r_sub_patch_width  <= pag_pkg::PSIDE_CFG_W'(14);
            r_merge_kernel     <= pag_pkg::KERN_CFG_W'(1);
            r_patch_limit      <= '0;
        end else if (i_cfg_we) begin
            case (pag_pkg::t_reg_idx'(i_cfg_index))
                pag_pkg::REG_BATCH_COUNT:
                    r_batch_count <= i_cfg_data[pag_pkg::BATCH_CFG_W-1:0];
                pag_pkg::REG_IMAGE_HEIGHT:
                    r_image_height <= i_cfg_data[pag_pkg::SIDE_W-1:0];
                pag_pkg::REG_IMAGE_WIDTH:
                    r_image_width <= i_cfg_data[pag_pkg::SIDE_W-1:0];
                pag_pkg::REG_CHANNEL_COUNT:
                    r_channel_count <= i_cfg_data[pag_pkg::CHAN_CFG_W-1:0];
                pag_pkg::REG_SUB_PATCH_HEIGHT:
                    r_sub_patch_height <= i_cfg_data[pag_pkg::PSIDE_CFG_W-1:0];
                pag_pkg::REG_SUB_PATCH_WIDTH:
                    r_sub_patch_width <= i_cfg_data[pag_pkg::PSIDE_CFG_W-1:0];
                pag_pkg::REG_MERGE_KERNEL:
                    r_merge_kernel <= i_cfg_data[pag_pkg::KERN_CFG_W-1:0];
                pag_pkg::REG_PATCH_LIMIT:
                    r_patch_limit <= i_cfg_data[pag_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate each register but the patch limit into its working range
    always_comb begin
        if (r_batch_count == '0) begin
            nb = pag_pkg::BATCH_CFG_W'(1);
        end else if (r_batch_count > pag_pkg::BATCH_CFG_W'(pag_pkg::MAX_BATCH)) begin
            nb = pag_pkg::BATCH_CFG_W'(pag_pkg::MAX_BATCH);
        end else begin
            nb = r_batch_count;
        end
        cfg.nb_m1 = pag_pkg::BPOS_W'(nb - 1'b1);

        if (r_image_height == '0) begin
            cfg.h = pag_pkg::SIDE_W'(1);
        end else if (r_image_height > pag_pkg::SIDE_W'(pag_pkg::MAX_SIDE)) begin
            cfg.h = pag_pkg::SIDE_W'(pag_pkg::MAX_SIDE);
        end else begin
            cfg.h = r_image_height;
        end

        if (r_image_width == '0) begin
            cfg.w = pag_pkg::SIDE_W'(1);
        end else if (r_image_width > pag_pkg::SIDE_W'(pag_pkg::MAX_SIDE)) begin
            cfg.w = pag_pkg::SIDE_W'(pag_pkg::MAX_SIDE);
        end else begin
            cfg.w = r_image_width;
        end

        if (r_channel_count == '0) begin
            cfg.c = pag_pkg::CHAN_CFG_W'(1);
        end else if (r_channel_count > pag_pkg::CHAN_CFG_W'(pag_pkg::MAX_CHANNELS)) begin
            cfg.c = pag_pkg::CHAN_CFG_W'(pag_pkg::MAX_CHANNELS);
        end else begin
            cfg.c = r_channel_count;
        end
        cfg.c_m1 = pag_pkg::CPOS_W'(cfg.c - 1'b1);

        if (r_sub_patch_height == '0) begin
            cfg.sph = pag_pkg::PSIDE_CFG_W'(1);
        end else if (r_sub_patch_height
                     > pag_pkg::PSIDE_CFG_W'(pag_pkg::MAX_PATCH_SIDE)) begin
            cfg.sph = pag_pkg::PSIDE_CFG_W'(pag_pkg::MAX_PATCH_SIDE);
        end else begin
            cfg.sph = r_sub_patch_height;
        end

        if (r_sub_patch_width == '0) begin
            cfg.spw = pag_pkg::PSIDE_CFG_W'(1);
        end else if (r_sub_patch_width
                     > pag_pkg::PSIDE_CFG_W'(pag_pkg::MAX_PATCH_SIDE)) begin
            cfg.spw = pag_pkg::PSIDE_CFG_W'(pag_pkg::MAX_PATCH_SIDE);
        end else begin
            cfg.spw = r_sub_patch_width;
        end

        if (r_merge_kernel == '0) begin
            cfg.k = pag_pkg::KERN_CFG_W'(1);
        end else if (r_merge_kernel > pag_pkg::KERN_CFG_W'(pag_pkg::MAX_KERNEL)) begin
            cfg.k = pag_pkg::KERN_CFG_W'(pag_pkg::MAX_KERNEL);
        end else begin
            cfg.k = r_merge_kernel;
        end

        cfg.limit = r_patch_limit;
    end

    assign flags.div_busy = div_rsp.busy;
    assign flags.in_valid = s_axis_tvalid;
    assign flags.out_full = r_out_valid & ~m_axis_tready;

    pag_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_flags   (flags),
        .o_ctrl    (ctrl),
        .o_fire    (fire)
    );

    pag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    pag_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_clear   (i_cfg_we),
        .i_ctrl    (ctrl),
        .i_fire    (fire),
        .i_restart (s_axis_tdata[0]),
        .i_div_rsp (div_rsp),
        .o_div_req (div_req),
        .o_result  (dp_result)
    );

    assign s_axis_tready = (ctrl.op == pag_pkg::OP_WAIT);
    assign emit_fire     = fire & (ctrl.op == pag_pkg::OP_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out <= dp_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.patch_start, r_out.patch_row, r_out.patch_col,
                            r_out.dest_index, r_out.source_index};
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != pag_pkg::ST_OK))
        |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("error word carries addresses or lacks last");

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("input taken right after a configuration write");

    a_one_word_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word taken before the first was emitted");

endmodule

@@ hw/rtl/pag_div.sv @@
// ----------------------------------------------------------------------------
// pag_div: restoring divider
// One quotient bit per cycle; busy from a start pulse until all SIDE_W quotient bits are formed.
// ----------------------------------------------------------------------------
module pag_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pag_pkg::t_div_req i_req,
    output pag_pkg::t_div_rsp o_rsp
);

    localparam int DCNT_W = $clog2(pag_pkg::SIDE_W + 1);

    logic                       r_busy;
    logic [DCNT_W-1:0]          r_cnt;
    logic [pag_pkg::SIDE_W-1:0] r_quot;
    logic [pag_pkg::MP_W-1:0]   r_rem;
    logic [pag_pkg::MP_W-1:0]   r_dvs;

    logic [pag_pkg::MP_W:0]   trial;
    logic [pag_pkg::MP_W+1:0] diff;
    logic                     ge;

    assign trial = {r_rem, r_quot[pag_pkg::SIDE_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_dvs};
    assign ge    = ~diff[pag_pkg::MP_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(pag_pkg::SIDE_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != DCNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[pag_pkg::SIDE_W-2:0], ge};
            r_rem  <= ge ? diff[pag_pkg::MP_W-1:0] : trial[pag_pkg::MP_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

@@ hw/rtl/pag_seq.sv @@
// ----------------------------------------------------------------------------
// pag_seq: microcode sequencer
// Step counter over a read-only program; each step holds on its wait
// condition and then jumps to the step named in its control word.
// ----------------------------------------------------------------------------
module pag_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  pag_pkg::t_flags  i_flags,
    output pag_pkg::t_ctrl   o_ctrl,
    output logic             o_fire
);

    localparam pag_pkg::t_pc S_MP       = 4'd0;
    localparam pag_pkg::t_pc S_DIVH_GO  = 4'd1;
    localparam pag_pkg::t_pc S_DIVH_END = 4'd2;
    localparam pag_pkg::t_pc S_DIVW_GO  = 4'd3;
    localparam pag_pkg::t_pc S_DIVW_END = 4'd4;
    localparam pag_pkg::t_pc S_CNT      = 4'd5;
    localparam pag_pkg::t_pc S_LIM      = 4'd6;
    localparam pag_pkg::t_pc S_CHECK    = 4'd7;
    localparam pag_pkg::t_pc S_WAIT     = 4'd8;
    localparam pag_pkg::t_pc S_MUL1     = 4'd9;
    localparam pag_pkg::t_pc S_MUL2     = 4'd10;
    localparam pag_pkg::t_pc S_EMIT     = 4'd11;

    function automatic pag_pkg::t_ctrl rom(input pag_pkg::t_pc pc);
        pag_pkg::t_ctrl w;
        case (pc)
            S_MP:       w = '{op: pag_pkg::OP_MP,       hold: pag_pkg::C_NONE,
                              next: S_DIVH_GO};
            S_DIVH_GO:  w = '{op: pag_pkg::OP_DIVH_GO,  hold: pag_pkg::C_NONE,
                              next: S_DIVH_END};
            S_DIVH_END: w = '{op: pag_pkg::OP_DIVH_END, hold: pag_pkg::C_DIV_BUSY,
                              next: S_DIVW_GO};
            S_DIVW_GO:  w = '{op: pag_pkg::OP_DIVW_GO,  hold: pag_pkg::C_NONE,
                              next: S_DIVW_END};
            S_DIVW_END: w = '{op: pag_pkg::OP_DIVW_END, hold: pag_pkg::C_DIV_BUSY,
                              next: S_CNT};
            S_CNT:      w = '{op: pag_pkg::OP_CNT,      hold: pag_pkg::C_NONE,
                              next: S_LIM};
            S_LIM:      w = '{op: pag_pkg::OP_LIM,      hold: pag_pkg::C_NONE,
                              next: S_CHECK};
            S_CHECK:    w = '{op: pag_pkg::OP_CHECK,    hold: pag_pkg::C_NONE,
                              next: S_WAIT};
            S_WAIT:     w = '{op: pag_pkg::OP_WAIT,     hold: pag_pkg::C_NO_INPUT,
                              next: S_MUL1};
            S_MUL1:     w = '{op: pag_pkg::OP_MUL1,     hold: pag_pkg::C_NONE,
                              next: S_MUL2};
            S_MUL2:     w = '{op: pag_pkg::OP_MUL2,     hold: pag_pkg::C_NONE,
                              next: S_EMIT};
            S_EMIT:     w = '{op: pag_pkg::OP_EMIT,     hold: pag_pkg::C_OUT_FULL,
                              next: S_WAIT};
            default:    w = '{op: pag_pkg::OP_NOP,      hold: pag_pkg::C_NONE,
                              next: S_MP};
        endcase
        return w;
    endfunction

    pag_pkg::t_pc   r_pc;
    pag_pkg::t_ctrl ctrl;
    logic           hold_now;

    assign ctrl = rom(r_pc);

    always_comb begin
        case (ctrl.hold)
            pag_pkg::C_NONE:     hold_now = 1'b0;
            pag_pkg::C_DIV_BUSY: hold_now = i_flags.div_busy;
            pag_pkg::C_NO_INPUT: hold_now = ~i_flags.in_valid;
            pag_pkg::C_OUT_FULL: hold_now = i_flags.out_full;
            default:             hold_now = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_MP;
        end else if (i_restart) begin
            r_pc <= S_MP;
        end else if (!hold_now) begin
            r_pc <= ctrl.next;
        end
    end

    assign o_ctrl = ctrl;
    assign o_fire = ~hold_now;

endmodule

@@ hw/rtl/pag_dp.sv @@
// ----------------------------------------------------------------------------
// pag_dp: address datapath
// Derived patch geometry, error status, walk counters and the two
// multiply steps that form the source index, driven by the control word.
// ----------------------------------------------------------------------------
module pag_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pag_pkg::t_cfg     i_cfg,
    input  logic              i_clear,
    input  pag_pkg::t_ctrl    i_ctrl,
    input  logic              i_fire,
    input  logic              i_restart,
    input  pag_pkg::t_div_rsp i_div_rsp,
    output pag_pkg::t_div_req o_div_req,
    output pag_pkg::t_result  o_result
);

    logic [pag_pkg::MP_W-1:0]    r_mph, r_mpw;
    logic [pag_pkg::KK_W-1:0]    r_kk;
    logic [pag_pkg::SIDE_W-1:0]  r_nph, r_npw;
    logic [pag_pkg::POS_W-1:0]   r_nph_m1, r_npw_m1;
    logic [pag_pkg::INNER_W-1:0] r_mph_m1, r_mpw_m1;
    logic                        r_rem_nz;
    logic [pag_pkg::PROD_W-1:0]  r_prod;
    logic [pag_pkg::PK_W-1:0]    r_prod_k;
    pag_pkg::t_status            r_status;
    logic [pag_pkg::P_W-1:0]     r_p;
    logic [pag_pkg::IDX_W-1:0]   r_q;

    logic [pag_pkg::BPOS_W-1:0]  r_bpos,  n_bpos;
    logic [pag_pkg::POS_W-1:0]   r_prow,  n_prow;
    logic [pag_pkg::POS_W-1:0]   r_pcol,  n_pcol;
    logic [pag_pkg::INNER_W-1:0] r_irow,  n_irow;
    logic [pag_pkg::INNER_W-1:0] r_icol,  n_icol;
    logic [pag_pkg::CPOS_W-1:0]  r_chan,  n_chan;
    logic [pag_pkg::IDX_W-1:0]   r_dest,  n_dest;
    logic [pag_pkg::ROWG_W-1:0]  r_row_base, n_row_base;
    logic [pag_pkg::POS_W-1:0]   r_col_base, n_col_base;

    logic                        go_w;
    logic [pag_pkg::ROWG_W-1:0]  img_row;
    logic [pag_pkg::POS_W-1:0]   img_col;
    logic [pag_pkg::IDX_W-1:0]   lin;
    logic                        err;
    logic                        at_last;
    logic                        emit;
    logic                        adv;
    logic                        clr;

    assign go_w = (i_ctrl.op == pag_pkg::OP_DIVW_GO);
    assign o_div_req.start    = i_fire & ((i_ctrl.op == pag_pkg::OP_DIVH_GO) | go_w);
    assign o_div_req.dividend = go_w ? i_cfg.w : i_cfg.h;
    assign o_div_req.divisor  = go_w ? r_mpw : r_mph;

    assign img_row = r_row_base + pag_pkg::ROWG_W'(r_irow);
    assign img_col = r_col_base + pag_pkg::POS_W'(r_icol);
    assign lin     = pag_pkg::IDX_W'(r_p) + pag_pkg::IDX_W'(img_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= pag_pkg::ST_OK;
        end else if (i_fire) begin
            case (i_ctrl.op)
                pag_pkg::OP_MP: begin
                    r_mph <= pag_pkg::MP_W'(pag_pkg::MPP_W'(i_cfg.sph)
                                            * pag_pkg::MPP_W'(i_cfg.k));
                    r_mpw <= pag_pkg::MP_W'(pag_pkg::MPP_W'(i_cfg.spw)
                                            * pag_pkg::MPP_W'(i_cfg.k));
                    r_kk  <= pag_pkg::KK_W'(i_cfg.k) * pag_pkg::KK_W'(i_cfg.k);
                end
                pag_pkg::OP_DIVH_END: begin
                    r_nph    <= i_div_rsp.quot;
                    r_nph_m1 <= pag_pkg::POS_W'(i_div_rsp.quot - 1'b1);
                    r_rem_nz <= (i_div_rsp.rem != '0);
                end
                pag_pkg::OP_DIVW_END: begin
                    r_npw    <= i_div_rsp.quot;
                    r_npw_m1 <= pag_pkg::POS_W'(i_div_rsp.quot - 1'b1);
                    r_rem_nz <= r_rem_nz | (i_div_rsp.rem != '0);
                end
                pag_pkg::OP_CNT: begin
                    r_prod <= pag_pkg::PROD_W'(r_nph) * pag_pkg::PROD_W'(r_npw);
                end
                pag_pkg::OP_LIM: begin
                    r_prod_k <= pag_pkg::PK_W'(r_prod) * pag_pkg::PK_W'(r_kk);
                end
                pag_pkg::OP_CHECK: begin
                    r_mph_m1 <= pag_pkg::INNER_W'(r_mph - 1'b1);
                    r_mpw_m1 <= pag_pkg::INNER_W'(r_mpw - 1'b1);
                    if (r_rem_nz) begin
                        r_status <= pag_pkg::ST_NOT_DIVISIBLE;
                    end else if ((i_cfg.limit != '0)
                                 && (r_prod_k > pag_pkg::PK_W'(i_cfg.limit))) begin
                        r_status <= pag_pkg::ST_TOO_MANY;
                    end else begin
                        r_status <= pag_pkg::ST_OK;
                    end
                end
                pag_pkg::OP_MUL1: begin
                    r_p <= pag_pkg::P_W'(img_row) * pag_pkg::P_W'(i_cfg.w);
                end
                pag_pkg::OP_MUL2: begin
                    r_q <= lin * pag_pkg::IDX_W'(i_cfg.c);
                end
                default: ;
            endcase
        end
    end

    assign err     = (r_status != pag_pkg::ST_OK);
    assign at_last = (r_bpos == i_cfg.nb_m1) && (r_prow == r_nph_m1)
                     && (r_pcol == r_npw_m1) && (r_irow == r_mph_m1)
                     && (r_icol == r_mpw_m1) && (r_chan == i_cfg.c_m1);
    assign emit    = i_fire & (i_ctrl.op == pag_pkg::OP_EMIT);
    assign adv     = emit & ~err & ~at_last;
    assign clr     = i_clear
                     | (i_fire & (i_ctrl.op == pag_pkg::OP_CHECK))
                     | (i_fire & (i_ctrl.op == pag_pkg::OP_WAIT) & i_restart)
                     | (emit & (err | at_last));

    always_comb begin
        n_bpos     = r_bpos;
        n_prow     = r_prow;
        n_pcol     = r_pcol;
        n_irow     = r_irow;
        n_icol     = r_icol;
        n_chan     = r_chan;
        n_dest     = r_dest;
        n_row_base = r_row_base;
        n_col_base = r_col_base;
        if (clr) begin
            n_bpos     = '0;
            n_prow     = '0;
            n_pcol     = '0;
            n_irow     = '0;
            n_icol     = '0;
            n_chan     = '0;
            n_dest     = '0;
            n_row_base = '0;
            n_col_base = '0;
        end else if (adv) begin
            n_dest = r_dest + 1'b1;
            if (r_chan != i_cfg.c_m1) begin
                n_chan = r_chan + 1'b1;
            end else begin
                n_chan = '0;
                if (r_icol != r_mpw_m1) begin
                    n_icol = r_icol + 1'b1;
                end else begin
                    n_icol = '0;
                    if (r_irow != r_mph_m1) begin
                        n_irow = r_irow + 1'b1;
                    end else begin
                        n_irow = '0;
                        if (r_pcol != r_npw_m1) begin
                            n_pcol     = r_pcol + 1'b1;
                            n_col_base = r_col_base + pag_pkg::POS_W'(r_mpw);
                        end else begin
                            n_pcol     = '0;
                            n_col_base = '0;
                            n_row_base = r_row_base + pag_pkg::ROWG_W'(r_mph);
                            if (r_prow != r_nph_m1) begin
                                n_prow = r_prow + 1'b1;
                            end else begin
                                n_prow = '0;
                                n_bpos = r_bpos + 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpos     <= '0;
            r_prow     <= '0;
            r_pcol     <= '0;
            r_irow     <= '0;
            r_icol     <= '0;
            r_chan     <= '0;
            r_dest     <= '0;
            r_row_base <= '0;
            r_col_base <= '0;
        end else begin
            r_bpos     <= n_bpos;
            r_prow     <= n_prow;
            r_pcol     <= n_pcol;
            r_irow     <= n_irow;
            r_icol     <= n_icol;
            r_chan     <= n_chan;
            r_dest     <= n_dest;
            r_row_base <= n_row_base;
            r_col_base <= n_col_base;
        end
    end

    always_comb begin
        if (err) begin
            o_result.source_index = '0;
            o_result.dest_index   = '0;
            o_result.patch_col    = '0;
            o_result.patch_row    = '0;
            o_result.patch_start  = 1'b0;
            o_result.last         = 1'b1;
            o_result.status       = r_status;
        end else begin
            o_result.source_index = r_q + pag_pkg::IDX_W'(r_chan);
            o_result.dest_index   = r_dest;
            o_result.patch_col    = r_pcol;
            o_result.patch_row    = r_prow;
            o_result.patch_start  = (r_irow == '0) && (r_icol == '0) && (r_chan == '0);
            o_result.last         = at_last;
            o_result.status       = pag_pkg::ST_OK;
        end
    end

endmodule
